// File: src/ish_pkg.sv
// ----------------------------------------------------------------------------
// ish_pkg
// Types, constants and helper functions shared by the chained hash blocks.
// ----------------------------------------------------------------------------
package ish_pkg;

  // Sequencer states of the chain controller.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } ctl_state_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_PIN_HEAD    = 2'd0;
  localparam logic [1:0] REG_PIN_TAIL    = 2'd1;
  localparam logic [1:0] REG_PIN_LENGTH  = 2'd2;
  localparam logic [1:0] REG_ROUND_COUNT = 2'd3;

  // Fixed 15-byte ASCII label that opens the first message.
  localparam logic [119:0] LABEL_TEXT = 120'h44352D45564F2D415554482D56317C;
  localparam int LABEL_BYTES  = 15;
  localparam int DIGEST_BYTES = 32;
  localparam int HEX_CHARS    = 32;

  // Command from the controller to the compression unit.
  typedef struct packed {
    logic init;   // load IV into chaining words and working registers
    logic load;   // copy chaining words into working registers
    logic step;   // one compression round
    logic fold;   // add working registers into chaining words
  } cmp_cmd_t;

  localparam logic [255:0] IV_WORDS = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // Uppercase ASCII hex character of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

endpackage

// File: src/ish_compress.sv
// ----------------------------------------------------------------------------
// ish_compress
// SHA-256 compression unit: one round per step, with a rolling 16-word
// message schedule held in shift registers.
// ----------------------------------------------------------------------------
module ish_compress (
  input  logic              clk,
  input  ish_pkg::cmp_cmd_t cmd,
  input  logic [5:0]        round_idx,
  input  logic [31:0]       msg_word,
  output logic [255:0]      chain_words
);

  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] sched_r [16];
  logic [255:0] chain_r;
  logic [31:0] w, t1, t2, s0, s1, w2, w15;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Message word for this round: input bytes first, then the schedule.
  always_comb begin
    w2  = sched_r[14];
    w15 = sched_r[1];
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    w   = (round_idx < 6'd16) ? msg_word : (s1 + sched_r[9] + s0 + sched_r[0]);
    t1  = h_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) +
          ((e_r & f_r) ^ (~e_r & g_r)) + ish_pkg::round_k(round_idx) + w;
    t2  = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) +
          ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  // Working registers, schedule window and chaining words.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      chain_r <= ish_pkg::IV_WORDS;
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= ish_pkg::IV_WORDS;
    end else if (cmd.load) begin
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= chain_r;
    end else if (cmd.step) begin
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[15] <= w;
    end else if (cmd.fold) begin
      chain_r <= {chain_r[255:224] + a_r, chain_r[223:192] + b_r,
                  chain_r[191:160] + c_r, chain_r[159:128] + d_r,
                  chain_r[127:96] + e_r, chain_r[95:64] + f_r,
                  chain_r[63:32] + g_r, chain_r[31:0] + h_r};
    end
  end

  assign chain_words = chain_r;

endmodule

// File: src/ish_msg_gen.sv
// ----------------------------------------------------------------------------
// ish_msg_gen
// Builds the padded message one 32-bit word at a time from label or digest,
// PIN bytes and challenge hex text.
// ----------------------------------------------------------------------------
module ish_msg_gen (
  input  logic         first_hash,
  input  logic         block_sel,
  input  logic [3:0]   word_sel,
  input  logic [255:0] digest,
  input  logic [127:0] pin_bytes,
  input  logic [4:0]   pin_len,
  input  logic [255:0] hex_text,
  output logic [31:0]  msg_word,
  output logic         two_blocks
);

  logic [7:0] head_len, msg_len, total_len, base, pos, rel;
  logic [15:0] bit_len;
  logic [7:0] byte_v [4];

  // Message length and padded size.
  always_comb begin
    head_len   = first_hash ? 8'(ish_pkg::LABEL_BYTES) : 8'(ish_pkg::DIGEST_BYTES);
    msg_len    = head_len + {3'd0, pin_len} + 8'(ish_pkg::HEX_CHARS);
    two_blocks = (msg_len > 8'd55);
    total_len  = two_blocks ? 8'd128 : 8'd64;
    bit_len    = {5'd0, msg_len, 3'd0};
    base       = {1'b0, block_sel, word_sel, 2'b00};
  end

  // One byte per lane: head, PIN, hex text, pad marker, zeros or length.
  always_comb begin
    pos = '0;
    rel = '0;
    for (int j = 0; j < 4; j++) begin
      pos = base + 8'(j);
      rel = '0;
      byte_v[j] = 8'h00;
      if (pos < head_len) begin
        if (first_hash) byte_v[j] = ish_pkg::LABEL_TEXT[8'd119 - {pos[4:0], 3'd0} -: 8];
        else            byte_v[j] = digest[8'd255 - {pos[4:0], 3'd0} -: 8];
      end else if (pos < head_len + {3'd0, pin_len}) begin
        rel = pos - head_len;
        byte_v[j] = pin_bytes[7'd127 - {rel[3:0], 3'd0} -: 8];
      end else if (pos < msg_len) begin
        rel = pos - head_len - {3'd0, pin_len};
        byte_v[j] = hex_text[8'd255 - {rel[4:0], 3'd0} -: 8];
      end else if (pos == msg_len) begin
        byte_v[j] = 8'h80;
      end else if (pos == total_len - 8'd2) begin
        byte_v[j] = bit_len[15:8];
      end else if (pos == total_len - 8'd1) begin
        byte_v[j] = bit_len[7:0];
      end
    end
    msg_word = {byte_v[0], byte_v[1], byte_v[2], byte_v[3]};
  end

endmodule

// File: src/iterated_sha256_auth_response.sv
// Each message block runs a load, 64 rounds and a fold; the first hash has one
// block for a PIN of up to eight bytes, else two, and each chained hash has two;
// a round count of zero counts as one.
// Throughput: one challenge at a time; busy stays high until the fourth word.
// The digest leaves as four beats on consecutive cycles; the receiver cannot stall.
// Reset (synchronous, active low) clears the sequencer; PIN empty, round count 2048.
// ----------------------------------------------------------------------------
// iterated_sha256_auth_response
// Chained SHA-256 over label, PIN and challenge hex text using one shared
// compression round unit under a small sequencer.
// ----------------------------------------------------------------------------
module iterated_sha256_auth_response (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_challenge_high,
  input  logic [63:0] in_challenge_low,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  output logic [63:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  ish_pkg::ctl_state_t state_r, state_nxt;
  logic [63:0]  pin_head_r, pin_tail_r;
  logic [4:0]   pin_length_r;
  logic [15:0]  round_count_r;
  logic [255:0] hex_r;
  logic [255:0] dig_r;
  logic [15:0]  done_r, done_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic         blk_r, blk_nxt, first_r, first_nxt;
  logic [1:0]   widx_r, widx_nxt;
  logic [4:0]   plen;
  logic [15:0]  target;
  logic [31:0]  msg_word;
  logic         two_blocks;
  logic [255:0] chain_words;
  logic [127:0] chal;
  logic [255:0] hex_text;
  ish_pkg::cmp_cmd_t cmd;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_head_r    <= '0;
      pin_tail_r    <= '0;
      pin_length_r  <= '0;
      round_count_r <= 16'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ish_pkg::REG_PIN_HEAD:    pin_head_r    <= cfg_data;
        ish_pkg::REG_PIN_TAIL:    pin_tail_r    <= cfg_data;
        ish_pkg::REG_PIN_LENGTH:  pin_length_r  <= cfg_data[4:0];
        ish_pkg::REG_ROUND_COUNT: round_count_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign plen   = (pin_length_r > 5'd16) ? 5'd16 : pin_length_r;
  assign target = (round_count_r == 16'd0) ? 16'd1 : round_count_r;

  // Hex text of the incoming challenge.
  assign chal = {in_challenge_high, in_challenge_low};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      hex_text[255 - 16*i -: 8] = ish_pkg::hex_char(chal[127 - 8*i -: 4]);
      hex_text[247 - 16*i -: 8] = ish_pkg::hex_char(chal[123 - 8*i -: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) hex_r <= hex_text;
  end

  // Previous digest, copied out of the chain words before the IV overwrites them.
  always_ff @(posedge clk) begin
    if (state_r == ish_pkg::ST_LOAD && !blk_r) dig_r <= chain_words;
  end

  ish_msg_gen u_msg (
    .first_hash (first_r),
    .block_sel  (blk_r),
    .word_sel   (rnd_r[3:0]),
    .digest     (dig_r),
    .pin_bytes  ({pin_head_r, pin_tail_r}),
    .pin_len    (plen),
    .hex_text   (hex_r),
    .msg_word   (msg_word),
    .two_blocks (two_blocks)
  );

  ish_compress u_cmp (
    .clk         (clk),
    .cmd         (cmd),
    .round_idx   (rnd_r),
    .msg_word    (msg_word),
    .chain_words (chain_words)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ish_pkg::ST_IDLE;
      done_r  <= '0;
      rnd_r   <= '0;
      blk_r   <= 1'b0;
      first_r <= 1'b1;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      rnd_r   <= rnd_nxt;
      blk_r   <= blk_nxt;
      first_r <= first_nxt;
      widx_r  <= widx_nxt;
    end
  end

  // Next state and unit commands. The first load of each hash restarts the
  // chaining words from the IV; the earlier digest is kept in its own register.
  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    rnd_nxt   = rnd_r;
    blk_nxt   = blk_r;
    first_nxt = first_r;
    widx_nxt  = widx_r;
    cmd       = '0;
    unique case (state_r)
      ish_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = ish_pkg::ST_LOAD;
          done_nxt  = '0;
          blk_nxt   = 1'b0;
          first_nxt = 1'b1;
          rnd_nxt   = '0;
        end
      end
      ish_pkg::ST_LOAD: begin
        if (!blk_r) cmd.init = 1'b1;
        else        cmd.load = 1'b1;
        state_nxt = ish_pkg::ST_ROUND;
        rnd_nxt   = '0;
      end
      ish_pkg::ST_ROUND: begin
        cmd.step = 1'b1;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = ish_pkg::ST_FOLD;
      end
      ish_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        rnd_nxt  = '0;
        if (two_blocks && !blk_r) begin
          blk_nxt   = 1'b1;
          state_nxt = ish_pkg::ST_LOAD;
        end else begin
          blk_nxt   = 1'b0;
          first_nxt = 1'b0;
          done_nxt  = done_r + 16'd1;
          if (done_r + 16'd1 >= target) begin
            state_nxt = ish_pkg::ST_EMIT;
            widx_nxt  = '0;
          end else begin
            state_nxt = ish_pkg::ST_LOAD;
          end
        end
      end
      ish_pkg::ST_EMIT: begin
        widx_nxt = widx_r + 2'd1;
        if (widx_r == 2'd3) state_nxt = ish_pkg::ST_IDLE;
      end
      default: state_nxt = ish_pkg::ST_IDLE;
    endcase
  end

  assign busy            = (state_r != ish_pkg::ST_IDLE);
  assign out_valid       = (state_r == ish_pkg::ST_EMIT);
  assign out_digest_word = chain_words[255 - 64*widx_r -: 64];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == 2'd3);

endmodule

// File: src/iterated_sha256_auth_response_chk.sv
// ----------------------------------------------------------------------------
// iterated_sha256_auth_response_chk
// Port-level checks on the result beats of the chained hash block.
// ----------------------------------------------------------------------------
module iterated_sha256_auth_response_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_word_index,
  input logic       out_last_word
);

  // A beat only leaves while the block is busy.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat while idle");

  // Last flag marks exactly word three.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 2'd3)))
    else $error("last flag mismatch");

  // Words follow each other on consecutive cycles.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_word) |=> (out_valid &&
      out_word_index == $past(out_word_index) + 2'd1))
    else $error("broken word sequence");

  // After the last word the block goes idle.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word) |=> !busy) else $error("busy after last word");

  // Accepted start raises busy.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");

endmodule

bind iterated_sha256_auth_response iterated_sha256_auth_response_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_word_index (out_word_index),
  .out_last_word  (out_last_word)
);
